// File: sv/csd_pkg.sv
// Shared types and constants for the channel section deframer.
// No dependencies; imported by every module of the block.
package csd_pkg;

    // Header byte layout: channel in the low bits, length minus one above
    localparam int CHAN_W      = 2;
    localparam int HDR_LEN_LSB = 2;
    localparam int HDR_LEN_W   = 6;
    localparam int PLEFT_W     = 7;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_LENGTH = 2'd2;

    // One input transaction
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic       data_valid;
        logic [7:0] out_byte;
        logic       section_last;
        logic       status;
    } t_out_item;

endpackage

// File: sv/csd_core.sv
// Deframing state and per-byte section logic of the channel section deframer.
// Depends on csd_pkg; instantiated by channel_section_deframer_top.
module csd_core
    import csd_pkg::*;
#(
    parameter int OFFSET_WIDTH = 24,
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  t_in_item                i_item,
    input  logic [CHAN_W-1:0]       i_channel,
    input  logic [OFFSET_WIDTH-1:0] i_start_offset,
    input  logic [LENGTH_WIDTH-1:0] i_section_length,
    output logic                    o_res_valid,
    output t_out_item               o_res
);

    localparam int CMP_W = (OFFSET_WIDTH > LENGTH_WIDTH) ? OFFSET_WIDTH : LENGTH_WIDTH;

    logic                    r_expect_header, n_expect_header;
    logic [PLEFT_W-1:0]      r_payload_left,  n_payload_left;
    logic                    r_frame_matches, n_frame_matches;
    logic [OFFSET_WIDTH-1:0] r_position,      n_position;
    logic                    r_section_done,  n_section_done;

    logic [OFFSET_WIDTH-1:0] rel;
    logic [CMP_W-1:0]        rel_ext;
    logic [CMP_W-1:0]        len_ext;
    logic                    len_nz;
    logic                    in_section;
    logic                    emit;
    logic                    last;
    logic                    done_after;
    logic                    incomplete;
    logic [PLEFT_W-1:0]      left_dec;

    // Position of the current byte relative to the section start
    assign rel     = r_position - i_start_offset;
    assign rel_ext = CMP_W'(rel);
    assign len_ext = CMP_W'(i_section_length);
    assign len_nz  = (i_section_length != '0);

    assign in_section = !r_section_done && len_nz && (r_position >= i_start_offset)
                        && (rel_ext < len_ext);
    assign emit       = !r_expect_header && r_frame_matches && in_section;
    assign last       = emit && (rel_ext == (len_ext - CMP_W'(1)));
    assign done_after = r_section_done || last;
    assign incomplete = i_item.end_of_stream && !done_after && len_nz;
    assign left_dec   = (r_payload_left != '0) ? (r_payload_left - PLEFT_W'(1)) : '0;

    // Next state for the byte in hand
    always_comb begin
        n_expect_header = r_expect_header;
        n_payload_left  = r_payload_left;
        n_frame_matches = r_frame_matches;
        n_position      = r_position;
        n_section_done  = done_after;
        if (r_expect_header) begin
            n_payload_left  = PLEFT_W'(i_item.stream_byte[HDR_LEN_LSB +: HDR_LEN_W])
                              + PLEFT_W'(1);
            n_frame_matches = (i_item.stream_byte[CHAN_W-1:0] == i_channel);
            n_expect_header = 1'b0;
        end else begin
            if (r_frame_matches) begin
                n_position = r_position + OFFSET_WIDTH'(1);
            end
            n_payload_left  = left_dec;
            n_expect_header = (left_dec == '0);
        end
        // Drop everything at the end of the stream
        if (i_item.end_of_stream) begin
            n_expect_header = 1'b1;
            n_payload_left  = '0;
            n_frame_matches = 1'b0;
            n_position      = '0;
            n_section_done  = 1'b0;
        end
    end

    // Advance state once per processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_payload_left  <= '0;
            r_frame_matches <= 1'b0;
            r_position      <= '0;
            r_section_done  <= 1'b0;
        end else if (i_fire) begin
            r_expect_header <= n_expect_header;
            r_payload_left  <= n_payload_left;
            r_frame_matches <= n_frame_matches;
            r_position      <= n_position;
            r_section_done  <= n_section_done;
        end
    end

    // Result for the byte in hand
    assign o_res_valid         = emit || incomplete;
    assign o_res.data_valid    = emit;
    assign o_res.out_byte      = emit ? i_item.stream_byte : 8'd0;
    assign o_res.section_last  = last;
    assign o_res.status        = incomplete;

endmodule

// File: sv/channel_section_deframer_top.sv
// A byte accepted into the input register passes any result it gives to the
// output register once that register is free. Throughput: one byte per cycle,
// limited only by the output stall; the input register and the output register
// each hold one transaction. Reset is synchronous, active low: it clears
// deframing state, empties both registers and returns configuration to
// channel 0, offset 0, length 1.
// Top level of the channel section deframer; depends on csd_pkg and csd_core.
module channel_section_deframer_top
    import csd_pkg::*;
#(
    parameter int OFFSET_WIDTH = 24,
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [((OFFSET_WIDTH > LENGTH_WIDTH) ? OFFSET_WIDTH : LENGTH_WIDTH)-1:0]
                                     i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_item
);

    logic [CHAN_W-1:0]       r_channel;
    logic [OFFSET_WIDTH-1:0] r_start_offset;
    logic [LENGTH_WIDTH-1:0] r_section_length;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_free;
    logic      fire;
    logic      in_accept;
    logic      res_valid;
    t_out_item res;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel        <= '0;
            r_start_offset   <= '0;
            r_section_length <= LENGTH_WIDTH'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNEL:        r_channel        <= i_cfg_data[CHAN_W-1:0];
                CFG_START_OFFSET:   r_start_offset   <= i_cfg_data[OFFSET_WIDTH-1:0];
                CFG_SECTION_LENGTH: r_section_length <= i_cfg_data[LENGTH_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: process the held byte when the output register can take a result
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    csd_core #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_item           (r_in_item),
        .i_channel        (r_channel),
        .i_start_offset   (r_start_offset),
        .i_section_length (r_section_length),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    // Output register: load a new result, or drop the one taken downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: sv/csd_checker.sv
// Port-level checks for the channel section deframer, bound to its top level.
// Depends on csd_pkg and channel_section_deframer_top.
module csd_checker
    import csd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result transaction changed");

    // The last section byte is a data byte and never an incomplete report
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.section_last |->
            o_out_item.data_valid && !o_out_item.status)
        else $error("section_last without data or with incomplete status");

    // Every result carries data or an incomplete report
    a_result_meaning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.data_valid || o_out_item.status)
        else $error("empty result transaction");

    // A report without data carries a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.data_valid |-> o_out_item.out_byte == 8'd0)
        else $error("nonzero byte without data_valid");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind channel_section_deframer_top csd_checker u_csd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
